FILE: design/hcbd_pkg.sv
// Shared types, codes and helpers of the chunked body decoder.
package hcbd_pkg;

  localparam int SIZE_BITS_DEF   = 32;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 2;
  localparam int LINE_W    = 16;
  localparam int BODY_W    = 32;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_LIMIT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TOTAL_CHECK  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LINE_LEN = 2'd2;

  // Result kinds
  localparam logic [1:0] K_NONE = 2'd0;
  localparam logic [1:0] K_BYTE = 2'd1;
  localparam logic [1:0] K_END  = 2'd2;
  localparam logic [1:0] K_ERR  = 2'd3;

  // Error codes
  localparam logic [2:0] ERR_NO_DIGITS   = 3'd0;
  localparam logic [2:0] ERR_CHUNK_LARGE = 3'd1;
  localparam logic [2:0] ERR_BODY_LARGE  = 3'd2;
  localparam logic [2:0] ERR_OVERFLOW    = 3'd3;
  localparam logic [2:0] ERR_LINE_LONG   = 3'd4;

  // Characters
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_VT  = 8'h0B;
  localparam logic [7:0] CH_FF  = 8'h0C;
  localparam logic [7:0] CH_SP  = 8'h20;

  typedef enum logic [5:0] {
    PH_SIZE       = 6'b000001,
    PH_DATA       = 6'b000010,
    PH_AFTER_DATA = 6'b000100,
    PH_LAST_LINE  = 6'b001000,
    PH_DONE       = 6'b010000,
    PH_ERROR      = 6'b100000
  } phase_t;

  // Classified wire byte handed from front to back
  typedef struct packed {
    logic [7:0] data;
    logic       is_lf;
    logic       is_cr;
    logic       is_blank;
    logic       is_hex;
    logic [3:0] hex;
  } class_t;

  typedef struct packed {
    logic [CFG_W-1:0]  size_limit;
    logic              total_check_enable;
    logic [LINE_W-1:0] max_line_len;
  } cfg_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [7:0]        payload_byte;
    logic [2:0]        error_code;
    logic [BODY_W-1:0] body_length;
  } result_t;

  function automatic logic [4:0] hex_lookup(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

endpackage

FILE: design/http_chunked_body_decoder.sv
// Chunked transfer body decoder: top level with configuration registers and result queue.
//
// Decodes an HTTP/1.1 chunked body one wire byte per clock while neither
// queue stalls, and gives exactly one result word per accepted byte: nothing,
// a payload byte, end of body, or an error (reported once, then input is
// ignored until rst). A byte pushed at one edge is classified into a short
// input queue, runs through the framing state machine in the next cycle when
// nothing stalls and is registered into the result queue, from which it can
// then be popped; the rate is set by the combinational size-line update
// (shift-add of the hex digit and the limit compare) in the back stage. Both
// queues hold QUEUE_DEPTH words, so either side may stall without the other.
// Registers are written through cfg_write/cfg_index/cfg_data; the user must
// write them only while the block is idle, not enforced here; index 3 is ignored.
module http_chunked_body_decoder import hcbd_pkg::*; #(
  parameter int SIZE_BITS   = SIZE_BITS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  logic [7:0]           wire_byte,
  output logic                 empty,
  input  logic                 pop,
  output logic [1:0]           kind,
  output logic [7:0]           payload_byte,
  output logic [2:0]           error_code,
  output logic [BODY_W-1:0]    body_length,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  cfg_t    cfg;
  class_t  cls;
  logic    avail;
  logic    take;
  logic    res_full;
  logic    res_push;
  result_t res_in;
  result_t res_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.size_limit         <= '0;
      cfg.total_check_enable <= 1'b1;
      cfg.max_line_len       <= LINE_W'(8192);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_SIZE_LIMIT:   cfg.size_limit         <= cfg_data;
        REG_TOTAL_CHECK:  cfg.total_check_enable <= cfg_data[0];
        REG_MAX_LINE_LEN: cfg.max_line_len       <= cfg_data[LINE_W-1:0];
        default: ;
      endcase
    end
  end

  hcbd_front #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .wire_byte (wire_byte),
    .take      (take),
    .avail     (avail),
    .cls       (cls)
  );

  hcbd_back #(
    .SIZE_BITS (SIZE_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .avail    (avail),
    .cls      (cls),
    .take     (take),
    .out_full (res_full),
    .out_push (res_push),
    .out_res  (res_in)
  );

  hcbd_queue #(
    .WIDTH ($bits(result_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_results (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .din   (res_in),
    .full  (res_full),
    .pop   (pop),
    .dout  (res_out),
    .empty (empty)
  );

  assign kind         = res_out.kind;
  assign payload_byte = res_out.payload_byte;
  assign error_code   = res_out.error_code;
  assign body_length  = res_out.body_length;

  a_payload_only_on_byte: assert property (@(posedge clk) disable iff (rst)
    (!empty && kind != K_BYTE) |-> payload_byte == 8'd0)
    else $error("payload byte set on a non-payload word");

  a_code_only_on_error: assert property (@(posedge clk) disable iff (rst)
    (!empty && kind != K_ERR) |-> error_code == ERR_NO_DIGITS)
    else $error("error code set on a non-error word");

  a_body_monotonic: assert property (@(posedge clk) disable iff (rst)
    (!empty && pop) ##1 !empty |-> body_length >= $past(body_length))
    else $error("body length went backwards between words");

endmodule

FILE: design/hcbd_queue.sv
// Small register FIFO used between the decoder stages and at the result side.
module hcbd_queue import hcbd_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == FULL_COUNT);
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: design/hcbd_front.sv
// Front stage: accepts wire bytes, classifies them and queues them for the back stage.
module hcbd_front import hcbd_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] wire_byte,
  input  logic       take,
  output logic       avail,
  output class_t     cls
);

  class_t     cls_in;
  logic [4:0] hx;
  logic       q_empty;

  always_comb begin
    hx              = hex_lookup(wire_byte);
    cls_in.data     = wire_byte;
    cls_in.is_lf    = (wire_byte == CH_LF);
    cls_in.is_cr    = (wire_byte == CH_CR);
    cls_in.is_blank = (wire_byte == CH_SP) || (wire_byte == CH_TAB) ||
                      (wire_byte == CH_VT) || (wire_byte == CH_FF) ||
                      (wire_byte == CH_CR);
    cls_in.is_hex   = hx[4];
    cls_in.hex      = hx[3:0];
  end

  hcbd_queue #(
    .WIDTH ($bits(class_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (cls_in),
    .full  (full),
    .pop   (take),
    .dout  (cls),
    .empty (q_empty)
  );

  assign avail = !q_empty;

endmodule

FILE: design/hcbd_back.sv
// Back stage: chunk framing state machine, size checks and result formation.
module hcbd_back import hcbd_pkg::*; #(
  parameter int SIZE_BITS = SIZE_BITS_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    avail,
  input  class_t  cls,
  output logic    take,
  input  logic    out_full,
  output logic    out_push,
  output result_t out_res
);

  localparam int WW = ((SIZE_BITS > BODY_W) ? SIZE_BITS : BODY_W) + 1;

  phase_t                phase, phase_next;
  logic [SIZE_BITS-1:0]  chunk_remaining, chunk_remaining_next;
  logic [SIZE_BITS-1:0]  size_accum, size_accum_next;
  logic                  digits_seen, digits_seen_next;
  logic                  digits_ended, digits_ended_next;
  logic [LINE_W-1:0]     line_length, line_length_next;
  logic [BODY_W-1:0]     body_count, body_count_next;

  logic [WW-1:0] accum_w;
  logic [WW-1:0] limit_w;
  logic [WW-1:0] total_w;
  logic          limit_on;
  logic          line_full;
  logic [1:0]    kind;
  logic [7:0]    pbyte;
  logic [2:0]    ecode;

  assign take     = avail && !out_full;
  assign out_push = take;

  assign accum_w   = {{(WW-SIZE_BITS){1'b0}}, size_accum};
  assign limit_w   = {{(WW-CFG_W){1'b0}}, cfg.size_limit};
  assign total_w   = {{(WW-BODY_W){1'b0}}, body_count} + accum_w;
  assign limit_on  = (cfg.size_limit != '0);
  assign line_full = (line_length >= cfg.max_line_len);

  always_comb begin
    phase_next           = phase;
    chunk_remaining_next = chunk_remaining;
    size_accum_next      = size_accum;
    digits_seen_next     = digits_seen;
    digits_ended_next    = digits_ended;
    line_length_next     = line_length;
    body_count_next      = body_count;
    kind                 = K_NONE;
    pbyte                = 8'd0;
    ecode                = ERR_NO_DIGITS;

    unique case (phase)
      PH_SIZE: begin
        if (cls.is_lf) begin
          if (!digits_seen) begin
            kind = K_ERR; ecode = ERR_NO_DIGITS;
          end else if (limit_on && accum_w > limit_w) begin
            kind = K_ERR; ecode = ERR_CHUNK_LARGE;
          end else if (cfg.total_check_enable && limit_on && total_w > limit_w) begin
            kind = K_ERR; ecode = ERR_BODY_LARGE;
          end else begin
            size_accum_next   = '0;
            digits_seen_next  = 1'b0;
            digits_ended_next = 1'b0;
            line_length_next  = '0;
            if (size_accum == '0) begin
              phase_next = PH_LAST_LINE;
            end else begin
              chunk_remaining_next = size_accum;
              phase_next           = PH_DATA;
            end
          end
        end else if (!cls.is_cr && line_full) begin
          kind = K_ERR; ecode = ERR_LINE_LONG;
        end else begin
          if (!cls.is_cr) begin
            line_length_next = line_length + 1'b1;
          end
          // blanks before the first digit are skipped
          if (!(!digits_seen && !digits_ended && cls.is_blank)) begin
            if (cls.is_hex && !digits_ended) begin
              if (size_accum[SIZE_BITS-1 -: 4] != 4'd0) begin
                kind = K_ERR; ecode = ERR_OVERFLOW;
              end else begin
                size_accum_next  = {size_accum[SIZE_BITS-5:0], cls.hex};
                digits_seen_next = 1'b1;
              end
            end else begin
              digits_ended_next = 1'b1;
            end
          end
        end
      end
      PH_DATA: begin
        kind  = K_BYTE;
        pbyte = cls.data;
        if (body_count != '1) begin
          body_count_next = body_count + 1'b1;
        end
        chunk_remaining_next = chunk_remaining - SIZE_BITS'(chunk_remaining != '0);
        if (chunk_remaining_next == '0) begin
          size_accum_next   = '0;
          digits_seen_next  = 1'b0;
          digits_ended_next = 1'b0;
          line_length_next  = '0;
          phase_next        = PH_AFTER_DATA;
        end
      end
      PH_AFTER_DATA, PH_LAST_LINE: begin
        if (cls.is_lf) begin
          size_accum_next   = '0;
          digits_seen_next  = 1'b0;
          digits_ended_next = 1'b0;
          line_length_next  = '0;
          if (phase == PH_LAST_LINE) begin
            phase_next = PH_DONE;
            kind       = K_END;
          end else begin
            phase_next = PH_SIZE;
          end
        end else if (!cls.is_cr && line_full) begin
          kind = K_ERR; ecode = ERR_LINE_LONG;
        end else if (!cls.is_cr) begin
          line_length_next = line_length + 1'b1;
        end
      end
      PH_DONE, PH_ERROR: begin
        kind = K_NONE;
      end
      default: begin
        kind = K_NONE;
      end
    endcase

    // an error freezes everything else
    if (kind == K_ERR) begin
      phase_next           = PH_ERROR;
      chunk_remaining_next = chunk_remaining;
      size_accum_next      = size_accum;
      digits_seen_next     = digits_seen;
      digits_ended_next    = digits_ended;
      line_length_next     = line_length;
      body_count_next      = body_count;
    end

    out_res.kind         = kind;
    out_res.payload_byte = pbyte;
    out_res.error_code   = (kind == K_ERR) ? ecode : ERR_NO_DIGITS;
    out_res.body_length  = body_count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_SIZE;
      chunk_remaining <= '0;
      size_accum      <= '0;
      digits_seen     <= 1'b0;
      digits_ended    <= 1'b0;
      line_length     <= '0;
      body_count      <= '0;
    end else if (take) begin
      phase           <= phase_next;
      chunk_remaining <= chunk_remaining_next;
      size_accum      <= size_accum_next;
      digits_seen     <= digits_seen_next;
      digits_ended    <= digits_ended_next;
      line_length     <= line_length_next;
      body_count      <= body_count_next;
    end
  end

endmodule
